[rtl/core/cdpc_pkg.sv]
package cdpc_pkg;

	localparam logic [1:0] CMD_LOAD_LEN  = 2'd0;
	localparam logic [1:0] CMD_LOAD_WAVE = 2'd1;
	localparam logic [1:0] CMD_CORRECT   = 2'd2;

	localparam int CORDIC_STEPS = 24;
	localparam int CORDIC_W     = 33;
	localparam int CORDIC_GAIN  = 652032874;
	localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
	localparam int COEF_FRAC    = 22;
	localparam int COEF_W       = 24;
	localparam int ISQ_W        = 21;
	localparam int ISQ_STAGES   = 5;

	function automatic logic [31:0] atan_turn(input int i);
		case (i)
			0:  atan_turn = 32'd536870912;
			1:  atan_turn = 32'd316933406;
			2:  atan_turn = 32'd167458907;
			3:  atan_turn = 32'd85004756;
			4:  atan_turn = 32'd42667331;
			5:  atan_turn = 32'd21354465;
			6:  atan_turn = 32'd10679838;
			7:  atan_turn = 32'd5340245;
			8:  atan_turn = 32'd2670163;
			9:  atan_turn = 32'd1335087;
			10: atan_turn = 32'd667544;
			11: atan_turn = 32'd333772;
			12: atan_turn = 32'd166886;
			13: atan_turn = 32'd83443;
			14: atan_turn = 32'd41722;
			15: atan_turn = 32'd20861;
			16: atan_turn = 32'd10430;
			17: atan_turn = 32'd5215;
			18: atan_turn = 32'd2608;
			19: atan_turn = 32'd1304;
			20: atan_turn = 32'd652;
			21: atan_turn = 32'd326;
			22: atan_turn = 32'd163;
			23: atan_turn = 32'd81;
			default: atan_turn = 32'd0;
		endcase
	endfunction

	// one digit of the bitwise square root, returns {remainder, root}
	function automatic logic [2*ISQ_W-1:0] isq_step(input logic [ISQ_W-1:0] n,
		input logic [ISQ_W-1:0] r, input logic [ISQ_W-1:0] b);
		logic [ISQ_W-1:0] rb;
		rb = r + b;
		if (n >= rb) begin
			isq_step = {n - rb, (r >> 1) + b};
		end else begin
			isq_step = {n, r >> 1};
		end
	endfunction

endpackage

[rtl/core/cdpc_ifs.sv]
interface cdpc_in_if #(parameter int SAMPLE_BITS = 24);
	logic                          valid;
	logic                          ready;
	logic [1:0]                    cmd;
	logic [15:0]                   index;
	logic signed [31:0]            value;
	logic [9:0]                    channel;
	logic signed [SAMPLE_BITS-1:0] re_xx;
	logic signed [SAMPLE_BITS-1:0] im_xx;
	logic signed [SAMPLE_BITS-1:0] re_xy;
	logic signed [SAMPLE_BITS-1:0] im_xy;
	logic signed [SAMPLE_BITS-1:0] re_yx;
	logic signed [SAMPLE_BITS-1:0] im_yx;
	logic signed [SAMPLE_BITS-1:0] re_yy;
	logic signed [SAMPLE_BITS-1:0] im_yy;

	modport source (output valid, cmd, index, value, channel, re_xx, im_xx, re_xy, im_xy,
		re_yx, im_yx, re_yy, im_yy, input ready);
	modport sink (input valid, cmd, index, value, channel, re_xx, im_xx, re_xy, im_xy,
		re_yx, im_yx, re_yy, im_yy, output ready);
endinterface

interface cdpc_out_if #(parameter int SAMPLE_BITS = 24);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] out_re_xx;
	logic signed [SAMPLE_BITS-1:0] out_im_xx;
	logic signed [SAMPLE_BITS-1:0] out_re_xy;
	logic signed [SAMPLE_BITS-1:0] out_im_xy;
	logic signed [SAMPLE_BITS-1:0] out_re_yx;
	logic signed [SAMPLE_BITS-1:0] out_im_yx;
	logic signed [SAMPLE_BITS-1:0] out_re_yy;
	logic signed [SAMPLE_BITS-1:0] out_im_yy;
	logic                          saturated;

	modport source (output valid, out_re_xx, out_im_xx, out_re_xy, out_im_xy, out_re_yx,
		out_im_yx, out_re_yy, out_im_yy, saturated, input ready);
	modport sink (input valid, out_re_xx, out_im_xx, out_re_xy, out_im_xy, out_re_yx,
		out_im_yx, out_re_yy, out_im_yy, saturated, output ready);
endinterface

[rtl/core/cdpc_ram.sv]
module cdpc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/core/cdpc_cordic.sv]
module cdpc_cordic import cdpc_pkg::*; #(
	parameter int PHASE_BITS = 12
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic [PHASE_BITS-1:0]    phase,
	output logic signed [COEF_W-1:0] cos_val,
	output logic signed [COEF_W-1:0] sin_val
);

	logic signed [CORDIC_W-1:0] x_s [CORDIC_STEPS+1];
	logic signed [CORDIC_W-1:0] y_s [CORDIC_STEPS+1];
	logic signed [CORDIC_W-1:0] z_s [CORDIC_STEPS+1];
	logic [1:0]                 q_s [CORDIC_STEPS+1];
	logic signed [CORDIC_W-1:0] c_d;
	logic signed [CORDIC_W-1:0] s_d;

	function automatic logic signed [COEF_W-1:0] coef_round(input logic signed [CORDIC_W-1:0] v);
		logic signed [CORDIC_W:0] t;
		logic signed [CORDIC_W:0] r;
		t = (CORDIC_W+1)'(v) + (CORDIC_W+1)'(128);
		r = t >>> 8;
		if (r > (CORDIC_W+1)'(1 << COEF_FRAC)) begin
			coef_round = COEF_W'(1 << COEF_FRAC);
		end else if (r < -(CORDIC_W+1)'(1 << COEF_FRAC)) begin
			coef_round = -COEF_W'(1 << COEF_FRAC);
		end else begin
			coef_round = COEF_W'(r);
		end
	endfunction

	// exact quarter-turn rotation
	always_comb begin
		case (q_s[CORDIC_STEPS])
			2'd0: begin
				c_d = x_s[CORDIC_STEPS];
				s_d = y_s[CORDIC_STEPS];
			end
			2'd1: begin
				c_d = -y_s[CORDIC_STEPS];
				s_d = x_s[CORDIC_STEPS];
			end
			2'd2: begin
				c_d = -x_s[CORDIC_STEPS];
				s_d = -y_s[CORDIC_STEPS];
			end
			default: begin
				c_d = y_s[CORDIC_STEPS];
				s_d = -x_s[CORDIC_STEPS];
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= CORDIC_W'(CORDIC_GAIN);
			y_s[0] <= '0;
			z_s[0] <= CORDIC_W'({phase[PHASE_BITS-3:0], {(32-PHASE_BITS){1'b0}}});
			q_s[0] <= phase[PHASE_BITS-1:PHASE_BITS-2];
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				if (!z_s[i][CORDIC_W-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - CORDIC_W'(atan_turn(i));
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + CORDIC_W'(atan_turn(i));
				end
				q_s[i+1] <= q_s[i];
			end
			cos_val <= coef_round(c_d);
			sin_val <= coef_round(s_d);
		end
	end

endmodule

[rtl/core/cable_delay_phase_correction.sv]
// channel   dir  kind         contents
// vis_in    in   valid/ready  cmd, index, value, channel, four complex samples
// vis_out   out  valid/ready  four rotated complex samples, saturated
//
// one item per cycle while no result is held at vis_out; the path of a correction
// runs through the root digits, the table read, the split phase multiply
// and the 24-step sine/cosine rotator
// loads take effect for every later item; tables are not cleared by arst_n
// a held result stalls the whole pipeline, and vis_in.ready follows
module cable_delay_phase_correction import cdpc_pkg::*; #(
	parameter int MAX_ANTENNAS = 256,
	parameter int MAX_CHANNELS = 1024,
	parameter int PHASE_BITS   = 12,
	parameter int SAMPLE_BITS  = 24
) (
	input  logic      clk,
	input  logic      arst_n,
	cdpc_in_if.sink   vis_in,
	cdpc_out_if.source vis_out
);

	localparam int AAW    = $clog2(MAX_ANTENNAS);
	localparam int CAW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int ST_RD  = 7;
	localparam int ST_CS  = 10 + CORDIC_LAT;
	localparam int ST_ACC = ST_CS + 2;
	localparam int PW     = SAMPLE_BITS + COEF_W;
	localparam int AW     = PW + 1;
	localparam logic signed [AW-1:0] SMAX = AW'((64'sd1 <<< (SAMPLE_BITS-1)) - 64'sd1);
	localparam logic signed [AW-1:0] SMIN = -SMAX - AW'(1);

	typedef struct packed {
		logic [1:0]                        cmd;
		logic [15:0]                       index;
		logic [31:0]                       value;
		logic [9:0]                        chan;
		logic [7:0][SAMPLE_BITS-1:0]       smp;
	} pl_t;

	logic                en;
	pl_t                 pl_in;
	pl_t                 pl_s [ST_CS+1];
	logic [ST_ACC:0]     vld_s;
	logic [ISQ_W-1:0]    sqn_s [ISQ_STAGES+1];
	logic [ISQ_W-1:0]    sqr_s [ISQ_STAGES+1];
	logic [ISQ_W-1:0]    mn_d [1:ISQ_STAGES];
	logic [ISQ_W-1:0]    mr_d [1:ISQ_STAGES];
	logic [ISQ_W-1:0]    sn_d [1:ISQ_STAGES];
	logic [ISQ_W-1:0]    sr_d [1:ISQ_STAGES];
	logic [9:0]          a1_d;
	logic [ISQ_W-1:0]    tri_d;
	logic [9:0]          a1_s6;
	logic [9:0]          a2_s6;
	logic                ok_s6;
	logic                len_we;
	logic                wave_we;
	logic [31:0]         len1_rd;
	logic [31:0]         len2_rd;
	logic [31:0]         wave_rd;
	logic signed [32:0]  d_s8;
	logic [31:0]         k_s8;
	logic [43:0]         m1_s9;
	logic [21:0]         m2_s9;
	logic [43:0]         ph_sum;
	logic [43:0]         ph_rnd;
	logic [PHASE_BITS-1:0] ph_s10;
	logic signed [COEF_W-1:0] cos_v;
	logic signed [COEF_W-1:0] sin_v;
	logic signed [PW-1:0] rc_s37 [4];
	logic signed [PW-1:0] is_s37 [4];
	logic signed [PW-1:0] ic_s37 [4];
	logic signed [PW-1:0] rs_s37 [4];
	logic signed [AW-1:0] acc_s38 [8];
	logic signed [AW-1:0] rnd_d [8];
	logic [7:0][SAMPLE_BITS-1:0] res_d;
	logic [7:0]           sat_d;
	logic                 out_valid_q;
	logic [7:0][SAMPLE_BITS-1:0] out_smp_q;
	logic                 out_sat_q;

	assign en = !out_valid_q || vis_out.ready;
	assign vis_in.ready = en;

	assign pl_in.cmd   = vis_in.cmd;
	assign pl_in.index = vis_in.index;
	assign pl_in.value = vis_in.value;
	assign pl_in.chan  = vis_in.channel;
	assign pl_in.smp   = {vis_in.im_yy, vis_in.re_yy, vis_in.im_yx, vis_in.re_yx,
		vis_in.im_xy, vis_in.re_xy, vis_in.im_xx, vis_in.re_xx};

	// triangular root, two digits a stage
	always_comb begin
		for (int j = 1; j <= ISQ_STAGES; j++) begin
			{mn_d[j], mr_d[j]} = isq_step(sqn_s[j-1], sqr_s[j-1], ISQ_W'(1) << (22 - 4*j));
			{sn_d[j], sr_d[j]} = isq_step(mn_d[j], mr_d[j], ISQ_W'(1) << (20 - 4*j));
		end
	end

	assign a1_d  = 10'((sqr_s[ISQ_STAGES] - ISQ_W'(1)) >> 1);
	assign tri_d = (ISQ_W'(a1_d) * ISQ_W'(a1_d + 10'd1)) >> 1;

	assign len_we  = en && vld_s[6] && pl_s[6].cmd == CMD_LOAD_LEN
		&& int'(pl_s[6].index) < MAX_ANTENNAS;
	assign wave_we = en && vld_s[6] && pl_s[6].cmd == CMD_LOAD_WAVE
		&& int'(pl_s[6].index) < MAX_CHANNELS;

	cdpc_ram #(.WIDTH(32), .DEPTH(MAX_ANTENNAS)) u_len1 (
		.clk   (clk),
		.we    (len_we),
		.waddr (AAW'(pl_s[6].index)),
		.wdata (pl_s[6].value),
		.re    (en),
		.raddr (AAW'(a1_s6)),
		.rdata (len1_rd)
	);

	cdpc_ram #(.WIDTH(32), .DEPTH(MAX_ANTENNAS)) u_len2 (
		.clk   (clk),
		.we    (len_we),
		.waddr (AAW'(pl_s[6].index)),
		.wdata (pl_s[6].value),
		.re    (en),
		.raddr (AAW'(a2_s6)),
		.rdata (len2_rd)
	);

	cdpc_ram #(.WIDTH(32), .DEPTH(MAX_CHANNELS)) u_wave (
		.clk   (clk),
		.we    (wave_we),
		.waddr (CAW'(pl_s[6].index)),
		.wdata (pl_s[6].value),
		.re    (en),
		.raddr (CAW'(pl_s[6].chan)),
		.rdata (wave_rd)
	);

	// phase in turns, low 44 bits of the product are all that matter
	assign ph_sum = m1_s9 + {m2_s9, 22'd0};
	assign ph_rnd = (44'd0 - ph_sum) + (44'd1 << (43 - PHASE_BITS));

	cdpc_cordic #(.PHASE_BITS(PHASE_BITS)) u_cordic (
		.clk     (clk),
		.en      (en),
		.phase   (ph_s10),
		.cos_val (cos_v),
		.sin_val (sin_v)
	);

	always_comb begin
		for (int j = 0; j < 8; j++) begin
			rnd_d[j] = (acc_s38[j] + AW'(1 << (COEF_FRAC - 1))) >>> COEF_FRAC;
			if (rnd_d[j] > SMAX) begin
				res_d[j] = SAMPLE_BITS'(SMAX);
				sat_d[j] = 1'b1;
			end else if (rnd_d[j] < SMIN) begin
				res_d[j] = SAMPLE_BITS'(SMIN);
				sat_d[j] = 1'b1;
			end else begin
				res_d[j] = SAMPLE_BITS'(rnd_d[j]);
				sat_d[j] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s       <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_s[0] <= vis_in.valid;
			for (int i = 1; i <= ST_ACC; i++) begin
				if (i == ST_RD) begin
					vld_s[i] <= vld_s[i-1] && pl_s[i-1].cmd == CMD_CORRECT && ok_s6;
				end else begin
					vld_s[i] <= vld_s[i-1];
				end
			end
			out_valid_q <= vld_s[ST_ACC];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pl_s[0]  <= pl_in;
			sqn_s[0] <= ISQ_W'({vis_in.index, 3'b000}) + ISQ_W'(1);
			sqr_s[0] <= '0;
			for (int i = 1; i <= ST_CS; i++) begin
				pl_s[i] <= pl_s[i-1];
			end
			for (int j = 1; j <= ISQ_STAGES; j++) begin
				sqn_s[j] <= sn_d[j];
				sqr_s[j] <= sr_d[j];
			end
			a1_s6 <= a1_d;
			a2_s6 <= 10'(pl_s[5].index - 16'(tri_d));
			ok_s6 <= int'(a1_d) < MAX_ANTENNAS && int'(pl_s[5].chan) < MAX_CHANNELS;
			d_s8  <= $signed({len2_rd[31], len2_rd}) - $signed({len1_rd[31], len1_rd});
			k_s8  <= wave_rd;
			m1_s9 <= 44'(44'(d_s8) * 44'($signed({1'b0, k_s8[21:0]})));
			m2_s9 <= d_s8[21:0] * {{12{k_s8[31]}}, k_s8[31:22]};
			ph_s10 <= ph_rnd[43:44-PHASE_BITS];
			for (int j = 0; j < 4; j++) begin
				rc_s37[j] <= PW'($signed(pl_s[ST_CS].smp[2*j])) * PW'(cos_v);
				is_s37[j] <= PW'($signed(pl_s[ST_CS].smp[2*j+1])) * PW'(sin_v);
				ic_s37[j] <= PW'($signed(pl_s[ST_CS].smp[2*j+1])) * PW'(cos_v);
				rs_s37[j] <= PW'($signed(pl_s[ST_CS].smp[2*j])) * PW'(sin_v);
				acc_s38[2*j]   <= AW'(rc_s37[j]) - AW'(is_s37[j]);
				acc_s38[2*j+1] <= AW'(ic_s37[j]) + AW'(rs_s37[j]);
			end
			out_smp_q <= res_d;
			out_sat_q <= |sat_d;
		end
	end

	assign vis_out.valid     = out_valid_q;
	assign vis_out.out_re_xx = out_smp_q[0];
	assign vis_out.out_im_xx = out_smp_q[1];
	assign vis_out.out_re_xy = out_smp_q[2];
	assign vis_out.out_im_xy = out_smp_q[3];
	assign vis_out.out_re_yx = out_smp_q[4];
	assign vis_out.out_im_yx = out_smp_q[5];
	assign vis_out.out_re_yy = out_smp_q[6];
	assign vis_out.out_im_yy = out_smp_q[7];
	assign vis_out.saturated = out_sat_q;

endmodule

[bench/testbench.sv]
module testbench;
	import cdpc_pkg::*;

	typedef struct {
		logic [1:0]         cmd;
		logic [15:0]        index;
		logic signed [31:0] value;
		logic [9:0]         channel;
		logic signed [23:0] smp [8];
	} vis_item_t;

	typedef struct {
		logic signed [23:0] smp [8];
		logic               sat;
	} vis_res_t;

	// rotation predictor and queue of expected corrected visibilities
	class vis_scoreboard;
		logic [31:0] len_tab [256];
		logic [31:0] wave_tab [1024];
		vis_res_t    rotated_q [$];
		int          n_checked;
		string       fld [8] = '{"re_xx", "im_xx", "re_xy", "im_xy",
			"re_yx", "im_yx", "re_yy", "im_yy"};
		longint      atan_tab [24] = '{536870912, 316933406, 167458907, 85004756,
			42667331, 21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772,
			166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

		function int unsigned root32(int unsigned n);
			int unsigned res;
			int unsigned b;
			res = 0;
			b = 32'h4000_0000;
			while (b > n) b = b >> 2;
			while (b != 0) begin
				if (n >= res + b) begin
					n = n - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
			return res;
		endfunction

		function longint coef_q22(longint v);
			longint r;
			r = (v + 128) >>> 8;
			if (r > 64'sd4194304) r = 64'sd4194304;
			if (r < -64'sd4194304) r = -64'sd4194304;
			return r;
		endfunction

		function void sin_cos(logic [11:0] phase, output longint c, output longint s);
			logic [31:0] turn;
			longint x, y, z, nx, ny;
			turn = {phase, 20'd0};
			z = longint'(turn[29:0]);
			x = 652032874;
			y = 0;
			for (int i = 0; i < 24; i++) begin
				if (z >= 0) begin
					nx = x - (y >>> i);
					ny = y + (x >>> i);
					z = z - atan_tab[i];
				end else begin
					nx = x + (y >>> i);
					ny = y - (x >>> i);
					z = z + atan_tab[i];
				end
				x = nx;
				y = ny;
			end
			case (turn[31:30])
				2'd0: begin c = x; s = y; end
				2'd1: begin c = -y; s = x; end
				2'd2: begin c = -x; s = -y; end
				default: begin c = y; s = -x; end
			endcase
			c = coef_q22(c);
			s = coef_q22(s);
		endfunction

		function logic signed [23:0] round_clip(longint acc, inout logic sat);
			longint r;
			r = (acc + 64'sd2097152) >>> 22;
			if (r > 64'sd8388607) begin r = 64'sd8388607; sat = 1'b1; end
			if (r < -64'sd8388608) begin r = -64'sd8388608; sat = 1'b1; end
			return r[23:0];
		endfunction

		function void note_input(vis_item_t it);
			int unsigned a1, a2;
			longint d, k, c, s, re, im;
			longint unsigned p;
			logic [11:0] ph;
			vis_res_t res;
			if (it.cmd == CMD_LOAD_LEN) begin
				if (it.index < 256) len_tab[it.index] = it.value;
				return;
			end
			if (it.cmd == CMD_LOAD_WAVE) begin
				if (it.index < 1024) wave_tab[it.index] = it.value;
				return;
			end
			if (it.cmd != CMD_CORRECT) return;
			a1 = (root32(8 * it.index + 1) - 1) / 2;
			a2 = it.index - (a1 * (a1 + 1)) / 2;
			if (a1 >= 256 || a2 >= 256) return;
			d = longint'($signed(len_tab[a2])) - longint'($signed(len_tab[a1]));
			k = longint'($signed(wave_tab[it.channel]));
			p = 64'd0 - longint'(d * k);
			ph = 12'((p + 64'h8000_0000) >> 32);
			sin_cos(ph, c, s);
			res.sat = 1'b0;
			for (int j = 0; j < 4; j++) begin
				re = longint'(it.smp[2 * j]);
				im = longint'(it.smp[2 * j + 1]);
				res.smp[2 * j] = round_clip(re * c - im * s, res.sat);
				res.smp[2 * j + 1] = round_clip(im * c + re * s, res.sat);
			end
			rotated_q.push_back(res);
		endfunction

		function string check_result(vis_res_t got);
			vis_res_t want;
			string msg;
			msg = "";
			if (rotated_q.size() == 0) return "result with no pending correction";
			want = rotated_q.pop_front();
			n_checked++;
			for (int j = 0; j < 8; j++)
				if (got.smp[j] !== want.smp[j])
					msg = {msg, $sformatf(" %s got %0d want %0d", fld[j], got.smp[j],
						want.smp[j])};
			if (got.sat !== want.sat)
				msg = {msg, $sformatf(" saturated got %0b want %0b", got.sat, want.sat)};
			if (msg != "") msg = $sformatf("result %0d:%s", n_checked, msg);
			return msg;
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   errors;
	int   src_idle;
	int   snk_idle;
	int   n_items;
	int   n_loads;
	int   n_corr;
	int   ant_list [$];
	int   ch_list [$];
	bit   ant_seen [256];
	bit   ch_seen [1024];
	vis_scoreboard sb;

	cdpc_in_if #(.SAMPLE_BITS(24))  vis_in ();
	cdpc_out_if #(.SAMPLE_BITS(24)) vis_out ();

	cable_delay_phase_correction dut (
		.clk    (clk),
		.arst_n (arst_n),
		.vis_in (vis_in.sink),
		.vis_out(vis_out.source)
	);

	always #4 clk = ~clk;

	task report(string m);
		errors++;
		if (errors <= 30) $display("MISMATCH: %s", m);
	endtask

	task send(vis_item_t it);
		while ($urandom_range(99) < src_idle) begin
			vis_in.valid <= 1'b0;
			@(posedge clk);
		end
		vis_in.valid   <= 1'b1;
		vis_in.cmd     <= it.cmd;
		vis_in.index   <= it.index;
		vis_in.value   <= it.value;
		vis_in.channel <= it.channel;
		vis_in.re_xx   <= it.smp[0];
		vis_in.im_xx   <= it.smp[1];
		vis_in.re_xy   <= it.smp[2];
		vis_in.im_xy   <= it.smp[3];
		vis_in.re_yx   <= it.smp[4];
		vis_in.im_yx   <= it.smp[5];
		vis_in.re_yy   <= it.smp[6];
		vis_in.im_yy   <= it.smp[7];
		do @(posedge clk); while (vis_in.ready !== 1'b1);
		sb.note_input(it);
		if (it.cmd == CMD_LOAD_LEN && it.index < 256) begin
			n_loads++;
			if (!ant_seen[it.index]) begin ant_seen[it.index] = 1; ant_list.push_back(it.index); end
		end
		if (it.cmd == CMD_LOAD_WAVE && it.index < 1024) begin
			n_loads++;
			if (!ch_seen[it.index]) begin ch_seen[it.index] = 1; ch_list.push_back(it.index); end
		end
		if (it.cmd == CMD_CORRECT) n_corr++;
	endtask

	function logic signed [23:0] rand_sample();
		case ($urandom_range(9))
			0: return 24'sh7FFFFF;
			1: return 24'sh800000;
			2: return 24'sd0;
			default: return 24'($urandom);
		endcase
	endfunction

	function vis_item_t make_item(logic [1:0] cmd, int idx, logic [31:0] v, int ch,
		bit extreme);
		vis_item_t it;
		it.cmd = cmd;
		it.index = idx[15:0];
		it.value = v;
		it.channel = ch[9:0];
		for (int j = 0; j < 8; j++)
			it.smp[j] = extreme ? ((j % 3 == 0) ? 24'sh800000 : 24'sh7FFFFF) : rand_sample();
		return it;
	endfunction

	function int pair_index(int a1, int a2);
		return a1 * (a1 + 1) / 2 + a2;
	endfunction

	task random_item();
		int r, a, b, t;
		vis_item_t it;
		r = $urandom_range(99);
		if (r < 18) begin
			it = make_item(CMD_LOAD_LEN, ($urandom_range(9) == 0) ? $urandom_range(65535)
				: $urandom_range(255), $urandom, 0, 0);
		end else if (r < 32) begin
			it = make_item(CMD_LOAD_WAVE, ($urandom_range(9) == 0) ? $urandom_range(65535)
				: $urandom_range(1023), $urandom, 0, 0);
		end else if (r < 93) begin
			a = ant_list[$urandom_range(ant_list.size() - 1)];
			b = ant_list[$urandom_range(ant_list.size() - 1)];
			if (b > a) begin t = a; a = b; b = t; end
			it = make_item(CMD_CORRECT, pair_index(a, b), $urandom,
				ch_list[$urandom_range(ch_list.size() - 1)], $urandom_range(19) == 0);
		end else if (r < 97) begin
			it = make_item(CMD_CORRECT, $urandom_range(65535, 32896), $urandom,
				$urandom_range(1023), 0);
		end else begin
			it = make_item(2'd3, $urandom_range(65535), $urandom, $urandom_range(1023), 0);
		end
		send(it);
		n_items++;
	endtask

	always @(posedge clk) begin
		vis_res_t got;
		string m;
		if (arst_n && vis_out.valid === 1'b1 && vis_out.ready === 1'b1) begin
			got.smp[0] = vis_out.out_re_xx;
			got.smp[1] = vis_out.out_im_xx;
			got.smp[2] = vis_out.out_re_xy;
			got.smp[3] = vis_out.out_im_xy;
			got.smp[4] = vis_out.out_re_yx;
			got.smp[5] = vis_out.out_im_yx;
			got.smp[6] = vis_out.out_re_yy;
			got.smp[7] = vis_out.out_im_yy;
			got.sat = vis_out.saturated;
			m = sb.check_result(got);
			if (m != "") report(m);
		end
		vis_out.ready <= ($urandom_range(99) >= snk_idle);
	end

	initial begin
		#4000000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		errors = 0;
		n_items = 0;
		n_loads = 0;
		n_corr = 0;
		src_idle = 13;
		snk_idle = 50;
		sb = new();
		vis_in.valid = 1'b0;
		vis_in.cmd = '0;
		vis_in.index = '0;
		vis_in.value = '0;
		vis_in.channel = '0;
		vis_in.re_xx = '0;
		vis_in.im_xx = '0;
		vis_in.re_xy = '0;
		vis_in.im_xy = '0;
		vis_in.re_yx = '0;
		vis_in.im_yx = '0;
		vis_in.re_yy = '0;
		vis_in.im_yy = '0;
		vis_out.ready = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: table extremes, ignored loads, unknown command, edge baselines
		send(make_item(CMD_LOAD_LEN, 0, 32'h7FFF_FFFF, 0, 0));
		send(make_item(CMD_LOAD_LEN, 255, 32'h8000_0000, 0, 0));
		send(make_item(CMD_LOAD_LEN, 1, 32'h0, 0, 0));
		send(make_item(CMD_LOAD_LEN, 128, $urandom, 0, 0));
		send(make_item(CMD_LOAD_WAVE, 0, 32'h7FFF_FFFF, 0, 0));
		send(make_item(CMD_LOAD_WAVE, 1023, 32'h8000_0000, 0, 0));
		send(make_item(CMD_LOAD_WAVE, 5, 32'h0, 0, 0));
		send(make_item(CMD_LOAD_WAVE, 700, $urandom, 0, 0));
		send(make_item(CMD_LOAD_LEN, 256, $urandom, 0, 0));
		send(make_item(CMD_LOAD_LEN, 65535, $urandom, 0, 0));
		send(make_item(CMD_LOAD_WAVE, 1024, $urandom, 0, 0));
		send(make_item(CMD_LOAD_WAVE, 65535, $urandom, 0, 0));
		send(make_item(2'd3, 0, $urandom, 0, 0));
		send(make_item(CMD_CORRECT, pair_index(0, 0), 0, 0, 1));
		send(make_item(CMD_CORRECT, pair_index(255, 0), 0, 1023, 1));
		send(make_item(CMD_CORRECT, pair_index(255, 255), 0, 0, 1));
		send(make_item(CMD_CORRECT, pair_index(1, 0), 0, 5, 1));
		send(make_item(CMD_CORRECT, pair_index(128, 1), 32'hFFFF_FFFF, 700, 0));
		send(make_item(CMD_CORRECT, pair_index(255, 128), 0, 1023, 0));
		send(make_item(CMD_CORRECT, 32896, 0, 0, 0));
		send(make_item(CMD_CORRECT, 65535, 0, 1023, 0));

		while (n_items < 450) random_item();
		vis_in.valid <= 1'b0;
		while (sb.rotated_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);

		src_idle = 50;
		snk_idle = 13;
		while (n_items < 900) random_item();
		src_idle = 0;
		snk_idle = 0;
		while (n_items < 1350) random_item();
		vis_in.valid <= 1'b0;

		while (sb.rotated_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (sb.rotated_q.size() != 0) report("corrections still pending at end");
		$display("covered %0d table loads and %0d corrections, %0d results checked",
			n_loads, n_corr, sb.n_checked);
		$display("tables touched: %0d antennas, %0d channels", ant_list.size(),
			ch_list.size());
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule

[sim.f]
rtl/core/cdpc_pkg.sv
rtl/core/cdpc_ifs.sv
rtl/core/cdpc_ram.sv
rtl/core/cdpc_cordic.sv
rtl/core/cable_delay_phase_correction.sv
bench/testbench.sv
